// ----- hw/rtl/sact_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package sact_pkg;
   localparam int SETS        = 64;
   localparam int WAYS        = 4;
   localparam int LINE_BYTES  = 64;
   localparam int ADDR_BITS   = 32;
   localparam int OFFSET_BITS = $clog2(LINE_BYTES);
   localparam int SET_BITS    = $clog2(SETS);
   localparam int WAY_BITS    = $clog2(WAYS);
   localparam int TAG_BITS    = 26;
   localparam int CNT_BITS    = 32;
   localparam int FUNC_BITS   = 2;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [FUNC_BITS-1:0] FUNC_WRITE = 2'd1;
   localparam logic [CNT_BITS-1:0]  CNT_MAX    = '1;

   typedef logic [WAYS-1:0][WAY_BITS-1:0] order_type;
   typedef logic [WAYS-1:0][TAG_BITS-1:0] tags_type;

   typedef struct packed {
      logic [SET_BITS-1:0] set_idx;
      logic [TAG_BITS-1:0] tag;
      logic                is_write;
   } lookup_type;

   typedef struct packed {
      order_type       order;
      logic [WAYS-1:0] dirty;
      logic [WAYS-1:0] valid;
      tags_type        tags;
   } row_type;

   localparam int ROW_BITS = $bits(row_type);

   // Way w sits at recency position w; position 0 is most recent.
   function automatic order_type reset_order();
      order_type o;
      for (int i = 0; i < WAYS; i++) begin
         o[i] = WAY_BITS'(i);
      end
      return o;
   endfunction

   function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] c);
      return (c == CNT_MAX) ? c : c + CNT_BITS'(1);
   endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/sact_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface sact_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] address;
   logic [1:0]  func;
   modport source(output valid, output address, output func, input ready);
   modport sink(input valid, input address, input func, output ready);
endinterface

interface sact_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic [1:0]  way_used;
   logic        writeback;
   logic [25:0] victim_tag;
   logic [31:0] access_count;
   logic [31:0] hit_count;
   logic [31:0] miss_count;
   logic [31:0] write_count;
   logic [31:0] writeback_count;
   modport source(output valid, output hit, output way_used, output writeback,
                  output victim_tag, output access_count, output hit_count,
                  output miss_count, output write_count, output writeback_count,
                  input ready);
   modport sink(input valid, input hit, input way_used, input writeback,
                input victim_tag, input access_count, input hit_count,
                input miss_count, input write_count, input writeback_count,
                output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/sact_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sact_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

// ----- hw/rtl/sact_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sact_front import sact_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   sact_req_if.sink        req,
   output lookup_type     q_head,
   output logic           q_valid,
   input  wire logic       q_pop
);
   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

   lookup_type              entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]       count_ff, count_in;
   logic                    push;
   lookup_type              decoded;

   assign req.ready = (count_ff < (PTR_BITS+1)'(QUEUE_DEPTH));
   assign push      = req.valid && req.ready;
   assign q_valid   = (count_ff != '0);
   assign q_head    = entry_ff[rd_ptr_ff];

   // Split the address into set and tag; offset bits drop out.
   always_comb begin
      decoded.set_idx  = req.address[OFFSET_BITS +: SET_BITS];
      decoded.tag      = TAG_BITS'(req.address[ADDR_BITS-1:OFFSET_BITS+SET_BITS]);
      decoded.is_write = (req.func == FUNC_WRITE);
   end

   always_comb begin
      wr_ptr_in = push ? PTR_BITS'((32'(wr_ptr_ff) + 1) % QUEUE_DEPTH) : wr_ptr_ff;
      rd_ptr_in = q_pop ? PTR_BITS'((32'(rd_ptr_ff) + 1) % QUEUE_DEPTH) : rd_ptr_ff;
      count_in  = count_ff + (PTR_BITS+1)'(push) - (PTR_BITS+1)'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= decoded;
      end
   end
endmodule
`default_nettype wire

// ----- hw/rtl/sact_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sact_back import sact_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire lookup_type   q_head,
   input  wire logic         q_valid,
   output logic              q_pop,
   sact_rsp_if.source        rsp
);
   typedef enum logic {ST_IDLE, ST_LOOKUP} state_type;

   state_type           state_ff;
   lookup_type          cur_ff;
   logic [SETS-1:0]     touched_ff;
   logic [CNT_BITS-1:0] acc_ff, hit_cnt_ff, miss_ff, wr_cnt_ff, wb_cnt_ff;
   logic [CNT_BITS-1:0] acc_in, hit_cnt_in, miss_in, wr_cnt_in, wb_cnt_in;
   logic                rsp_valid_ff;

   logic                ram_rd_en, ram_wr_en;
   logic [ROW_BITS-1:0] ram_rd_data;
   row_type             row, row_in;
   logic                hit, found, wb, finish;
   logic [WAY_BITS-1:0] way;
   logic [WAY_BITS-1:0] pos;
   logic [TAG_BITS-1:0] vtag;

   sact_ram #(.WIDTH(ROW_BITS), .DEPTH(SETS)) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (cur_ff.set_idx),
      .wr_data (row_in),
      .rd_en   (ram_rd_en),
      .rd_addr (q_head.set_idx),
      .rd_data (ram_rd_data)
   );

   assign q_pop     = (state_ff == ST_IDLE) && q_valid;
   assign ram_rd_en = q_pop;
   assign finish    = (state_ff == ST_LOOKUP) && (!rsp_valid_ff || rsp.ready);
   assign ram_wr_en = finish;
   assign rsp.valid = rsp_valid_ff;

   always_comb begin
      row = ram_rd_data;
      if (!touched_ff[cur_ff.set_idx]) begin
         row.order = reset_order();
         row.dirty = '0;
         row.valid = '0;
      end
   end

   // Tag compare, victim pick and recency update for the set.
   always_comb begin
      hit   = 1'b0;
      found = 1'b0;
      way   = '0;
      pos   = WAY_BITS'(WAYS-1);
      for (int w = WAYS-1; w >= 0; w--) begin
         if (row.valid[w] && row.tags[w] == cur_ff.tag) begin
            hit = 1'b1;
            way = WAY_BITS'(w);
         end
      end
      if (!hit) begin
         for (int w = WAYS-1; w >= 0; w--) begin
            if (!row.valid[w]) begin
               found = 1'b1;
               way   = WAY_BITS'(w);
            end
         end
         if (!found) begin
            way = row.order[WAYS-1];
         end
      end
      wb   = !hit && row.valid[way] && row.dirty[way];
      vtag = wb ? row.tags[way] : '0;
      for (int p = WAYS-1; p >= 0; p--) begin
         if (row.order[p] == way) begin
            pos = WAY_BITS'(p);
         end
      end
      row_in = row;
      if (hit) begin
         if (cur_ff.is_write) begin
            row_in.dirty[way] = 1'b1;
         end
      end else begin
         row_in.tags[way]  = cur_ff.tag;
         row_in.valid[way] = 1'b1;
         row_in.dirty[way] = cur_ff.is_write;
      end
      for (int p = 1; p < WAYS; p++) begin
         if (WAY_BITS'(p) <= pos) begin
            row_in.order[p] = row.order[p-1];
         end
      end
      row_in.order[0] = way;
   end

   always_comb begin
      acc_in     = sat_inc(acc_ff);
      hit_cnt_in = hit ? sat_inc(hit_cnt_ff) : hit_cnt_ff;
      miss_in    = hit ? miss_ff : sat_inc(miss_ff);
      wr_cnt_in  = cur_ff.is_write ? sat_inc(wr_cnt_ff) : wr_cnt_ff;
      wb_cnt_in  = wb ? sat_inc(wb_cnt_ff) : wb_cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         touched_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         hit_cnt_ff   <= '0;
         miss_ff      <= '0;
         wr_cnt_ff    <= '0;
         wb_cnt_ff    <= '0;
      end else begin
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  cur_ff   <= q_head;
                  state_ff <= ST_LOOKUP;
               end
            end
            ST_LOOKUP: begin
               if (finish) begin
                  touched_ff[cur_ff.set_idx] <= 1'b1;
                  acc_ff       <= acc_in;
                  hit_cnt_ff   <= hit_cnt_in;
                  miss_ff      <= miss_in;
                  wr_cnt_ff    <= wr_cnt_in;
                  wb_cnt_ff    <= wb_cnt_in;
                  rsp.hit             <= hit;
                  rsp.way_used        <= 2'(way);
                  rsp.writeback       <= wb;
                  rsp.victim_tag      <= vtag;
                  rsp.access_count    <= acc_in;
                  rsp.hit_count       <= hit_cnt_in;
                  rsp.miss_count      <= miss_in;
                  rsp.write_count     <= wr_cnt_in;
                  rsp.writeback_count <= wb_cnt_in;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ----- hw/rtl/set_assoc_cache_tag_store.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Flow: a request is queued, popped as its set row is read, then resolved in lookup state.
// No new request is popped until the read-modify-write of the set row (tags, state and
// recency order) in the tag RAM has finished; a held response stalls the next one.
// Reset: synchronous, active high; clears queue, counters and per-set touched flags,
// so all lines read invalid and recency returns to way order without a clearing pass.
module set_assoc_cache_tag_store import sact_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   sact_req_if.sink   req,
   sact_rsp_if.source rsp
);
   lookup_type q_head;
   logic       q_valid;
   logic       q_pop;

   // Front end: accept requests, decode set and tag, hold them in a short queue.
   sact_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .q_head  (q_head),
      .q_valid (q_valid),
      .q_pop   (q_pop)
   );

   // Back end: read the set row, resolve hit or victim, write the row back,
   // advance the counters and hold the response until taken.
   sact_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_head  (q_head),
      .q_valid (q_valid),
      .q_pop   (q_pop),
      .rsp     (rsp)
   );
endmodule
`default_nettype wire

// ----- hw/rtl/sact_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sact_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        writeback,
   input wire logic [25:0] victim_tag,
   input wire logic [31:0] access_count,
   input wire logic [31:0] hit_count,
   input wire logic [31:0] miss_count
);
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(access_count))
      else $error("stalled response changed");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && access_count != 32'hFFFFFFFF
      |=> !rsp_valid || access_count == $past(access_count) + 32'd1)
      else $error("access count skipped");

   a_split: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && access_count != 32'hFFFFFFFF
      |-> {1'b0, hit_count} + {1'b0, miss_count} == {1'b0, access_count})
      else $error("hits plus misses differ from accesses");

   a_victim_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !writeback |-> victim_tag == 26'd0)
      else $error("victim tag without writeback");
endmodule

bind set_assoc_cache_tag_store sact_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .writeback    (rsp.writeback),
   .victim_tag   (rsp.victim_tag),
   .access_count (rsp.access_count),
   .hit_count    (rsp.hit_count),
   .miss_count   (rsp.miss_count)
);
`default_nettype wire
